[src/dual_axis_pid_balance_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dual-axis balance controller
// Short forms for concurrent checks clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef DUAL_AXIS_PID_BALANCE_MACROS_SVH
`define DUAL_AXIS_PID_BALANCE_MACROS_SVH

// Check that is ignored while reset is asserted
`define DAPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that holds on every edge, reset included
`define DAPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/dapb_pkg.sv]
// ----------------------------------------------------------------------------
// dapb_pkg
// Types, constants and codes shared by the balance controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package dapb_pkg;

  // Default accumulator width
  localparam int DEF_ACCUM_WIDTH = 40;

  // Gain fraction bits and time scale
  localparam int GAIN_FRAC_BITS = 8;
  localparam logic [19:0] US_PER_SEC = 20'd1000000;

  // Integral scale 2^8 * 10^6 = 2^14 * 15625; the odd factor is removed by a
  // reciprocal multiply (floor(2^33 / 15625)) and one compare and correct
  localparam int          INTEG_SHIFT = 14;
  localparam logic [14:0] INTEG_ODD   = 15'd15625;
  localparam logic [19:0] INTEG_RECIP = 20'd549755;
  localparam int          RECIP_SHIFT = 33;

  // Shared multiplier and divider widths
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 20;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 28;

  // Register map
  typedef enum logic [2:0] {
    REG_PITCH_PROP  = 3'd0,
    REG_PITCH_INTEG = 3'd1,
    REG_PITCH_DERIV = 3'd2,
    REG_ROLL_PROP   = 3'd3,
    REG_ROLL_INTEG  = 3'd4,
    REG_ROLL_DERIV  = 3'd5,
    REG_DEAD_ZONE   = 3'd6,
    REG_CORR_LIMIT  = 3'd7
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MD1,
    ST_MD2,
    ST_DIVD,
    ST_BND,
    ST_DIVB,
    ST_CLMP,
    ST_MI1,
    ST_MI2,
    ST_MI3,
    ST_RC1,
    ST_RC2,
    ST_SUM,
    ST_NEXT
  } seq_state_e;

  // Input beat
  typedef struct packed {
    logic               kind;
    logic               enabled;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic        [15:0] time_step;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic signed [15:0] pitch_correction;
    logic signed [15:0] roll_correction;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[src/dual_axis_pid_balance.sv]
// ----------------------------------------------------------------------------
// dual_axis_pid_balance
// Pitch and roll PID loops with deadband, clamped terms and anti-windup.
// ----------------------------------------------------------------------------
// One sequencer runs the pitch loop and then the roll loop through a single
// 32x20 multiplier and a 52-step restoring divider. In an update with both
// loops active, each loop makes two divider passes (derivative and integral
// bound) plus multiplies and clamps, the fixed integral scale being taken by a
// reciprocal multiply; the bound pass is skipped when that loop's integral
// gain is zero. A loop inside the deadband, at zero error or with a zero time
// step skips the divider passes and multiplies. Clear beats and disabled beats
// skip both loops. The input stalls until the result beat has been taken.
`default_nettype none

module dual_axis_pid_balance
  import dapb_pkg::*;
#(
  parameter int ACCUM_WIDTH = DEF_ACCUM_WIDTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_item_o
);

`include "dual_axis_pid_balance_macros.svh"

  localparam int SW = ((ACCUM_WIDTH > 45) ? ACCUM_WIDTH : 45) + 2;
  localparam logic signed [SW-1:0] ACC_MAX =
    {{(SW - ACCUM_WIDTH + 1){1'b0}}, {(ACCUM_WIDTH - 1){1'b1}}};

  // Configuration
  logic [15:0] kp_q [2];
  logic [15:0] ki_q [2];
  logic [15:0] kd_q [2];
  logic [14:0] dz_q;
  logic [14:0] lim_q;

  // Loop state
  logic signed [ACCUM_WIDTH-1:0] acc_q  [2];
  logic signed [15:0]            last_q [2];
  logic [1:0]                    fresh_q;

  // Sequencer and working registers
  seq_state_e         state_q, state_d;
  logic               ax_q;
  in_item_t           item_q;
  logic [16:0]        emag_q;
  logic               eneg_q;
  logic               dneg_q;
  logic [14:0]        dmag_q;
  logic [MUL_PW-1:0]  prod_q;
  logic [47:0]        ip_q;
  logic [43:0]        bound_q;
  logic [43:0]        amag_q;
  logic               aneg_q;
  logic [28:0]        nq_q;
  logic [23:0]        pmag_q;
  logic [15:0]        q0_q;
  logic signed [15:0] corr_q [2];
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic     in_beat;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  logic signed [15:0] cur_e;
  logic signed [15:0] last_eff;
  logic signed [16:0] e_ext;
  logic signed [16:0] diff;
  logic [16:0]        emag;
  logic [16:0]        dmag17;
  logic               in_dead;
  logic               e_zero;
  logic [15:0]        ki_cur;

  logic signed [SW-1:0] acc_ext;
  logic signed [SW-1:0] x_s;
  logic signed [SW-1:0] acc_raw;
  logic signed [SW-1:0] acc_sum;
  logic signed [SW-1:0] bnd_s;
  logic signed [SW-1:0] acc_clmp;
  logic signed [SW-1:0] amag_full;
  logic [14:0]          dclip;

  logic [DIV_NW-1:0]  isum;
  logic [28:0]        rc_rem;
  logic [15:0]        iq;
  logic signed [26:0] p_s;
  logic signed [26:0] i_s;
  logic signed [26:0] d_s;
  logic signed [26:0] tot_s;
  logic signed [26:0] lim_s;
  logic signed [15:0] corr_c;

  dapb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '{default: '0};
      ki_q  <= '{default: '0};
      kd_q  <= '{default: '0};
      dz_q  <= '0;
      lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PITCH_PROP:  kp_q[0] <= cfg_data_i;
        REG_PITCH_INTEG: ki_q[0] <= cfg_data_i;
        REG_PITCH_DERIV: kd_q[0] <= cfg_data_i;
        REG_ROLL_PROP:   kp_q[1] <= cfg_data_i;
        REG_ROLL_INTEG:  ki_q[1] <= cfg_data_i;
        REG_ROLL_DERIV:  kd_q[1] <= cfg_data_i;
        REG_DEAD_ZONE:   dz_q    <= cfg_data_i[14:0];
        REG_CORR_LIMIT:  lim_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Error, deadband and difference of the selected loop
  always_comb begin
    cur_e    = ax_q ? item_q.roll_angle : item_q.pitch_angle;
    ki_cur   = ki_q[ax_q];
    e_ext    = {cur_e[15], cur_e};
    emag     = e_ext[16] ? 17'(-e_ext) : 17'(e_ext);
    in_dead  = emag < {2'b00, dz_q};
    e_zero   = in_dead || (cur_e == 16'sd0);
    last_eff = fresh_q[ax_q] ? cur_e : last_q[ax_q];
    diff     = e_ext - $signed({last_eff[15], last_eff});
    dmag17   = diff[16] ? 17'(-diff) : 17'(diff);
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_PREP: begin
        mul_a = MUL_AW'(dmag17[15:0]);
        mul_b = MUL_BW'(kd_q[ax_q]);
      end
      ST_MD1: begin
        mul_a = prod_q[MUL_AW-1:0];
        mul_b = US_PER_SEC;
      end
      ST_MD2: begin
        mul_a = MUL_AW'(emag_q);
        mul_b = MUL_BW'(item_q.time_step);
      end
      ST_DIVD: begin
        mul_a = (ki_cur != 16'd0) ? MUL_AW'({lim_q, 8'h00}) : MUL_AW'(lim_q);
        mul_b = US_PER_SEC;
      end
      ST_MI1: begin
        mul_a = amag_q[31:0];
        mul_b = MUL_BW'(ki_cur);
      end
      ST_MI2: begin
        mul_a = MUL_AW'(amag_q[43:32]);
        mul_b = MUL_BW'(ki_cur);
      end
      ST_MI3: begin
        mul_a = MUL_AW'(emag_q);
        mul_b = MUL_BW'(kp_q[ax_q]);
      end
      ST_RC1: begin
        mul_a = MUL_AW'(nq_q);
        mul_b = INTEG_RECIP;
      end
      ST_RC2: begin
        mul_a = MUL_AW'(prod_q[RECIP_SHIFT+15:RECIP_SHIFT]);
        mul_b = MUL_BW'(INTEG_ODD);
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Accumulate with saturation, then clamp to the integral bound
  always_comb begin
    acc_ext = SW'(acc_q[ax_q]);
    x_s     = $signed({{(SW - 32){1'b0}}, prod_q[31:0]});
    if (eneg_q) begin
      x_s = -x_s;
    end
    acc_raw = acc_ext + x_s;
    if (acc_raw > ACC_MAX) begin
      acc_sum = ACC_MAX;
    end else if (acc_raw < -ACC_MAX) begin
      acc_sum = -ACC_MAX;
    end else begin
      acc_sum = acc_raw;
    end
    bnd_s = $signed({{(SW - 44){1'b0}}, bound_q});
    if (bnd_s > ACC_MAX) begin
      bnd_s = ACC_MAX;
    end
    if (acc_ext > bnd_s) begin
      acc_clmp = bnd_s;
    end else if (acc_ext < -bnd_s) begin
      acc_clmp = -bnd_s;
    end else begin
      acc_clmp = acc_ext;
    end
    amag_full = acc_clmp[SW-1] ? -acc_clmp : acc_clmp;
    dclip     = (div_rsp.quot > DIV_NW'(lim_q)) ? lim_q : div_rsp.quot[14:0];
  end

  // Full integral product |accum| * gain from its two partial products
  assign isum = DIV_NW'(ip_q) + {prod_q[19:0], 32'h0000_0000};

  // Correct the reciprocal estimate, sum the terms and clamp the correction
  always_comb begin
    rc_rem = nq_q - prod_q[28:0];
    iq     = (rc_rem >= 29'(INTEG_ODD)) ? q0_q + 16'd1 : q0_q;
    p_s    = $signed({3'b000, pmag_q});
    i_s    = $signed({12'h000, iq[14:0]});
    d_s    = $signed({12'h000, dmag_q});
    lim_s  = $signed({12'h000, lim_q});
    if (eneg_q) begin
      p_s = -p_s;
    end
    if (aneg_q) begin
      i_s = -i_s;
    end
    if (dneg_q) begin
      d_s = -d_s;
    end
    tot_s = p_s + i_s + d_s;
    if (tot_s > lim_s) begin
      tot_s = lim_s;
    end else if (tot_s < -lim_s) begin
      tot_s = -lim_s;
    end
    corr_c = tot_s[15:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = (in_item_i.kind || !in_item_i.enabled) ? ST_NEXT : ST_PREP;
        end
      end
      ST_PREP: state_d = (e_zero || item_q.time_step == 16'd0) ? ST_NEXT : ST_MD1;
      ST_MD1:  state_d = ST_MD2;
      ST_MD2:  state_d = ST_DIVD;
      ST_DIVD: begin
        if (div_rsp.done) begin
          state_d = ST_BND;
        end
      end
      ST_BND:  state_d = (ki_cur != 16'd0) ? ST_DIVB : ST_CLMP;
      ST_DIVB: begin
        if (div_rsp.done) begin
          state_d = ST_CLMP;
        end
      end
      ST_CLMP: state_d = ST_MI1;
      ST_MI1:  state_d = ST_MI2;
      ST_MI2:  state_d = ST_MI3;
      ST_MI3:  state_d = ST_RC1;
      ST_RC1:  state_d = ST_RC2;
      ST_RC2:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_NEXT;
      ST_NEXT: state_d = ax_q ? ST_IDLE : ST_PREP;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and divider requests
  always_comb begin
    in_stall_o       = (state_q != ST_IDLE) || out_valid_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      ST_MD2: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = DIV_DW'({item_q.time_step, 8'h00});
      end
      ST_BND: begin
        div_req.start    = (ki_cur != 16'd0);
        div_req.dividend = prod_q;
        div_req.divisor  = DIV_DW'(ki_cur);
      end
      default: ;
    endcase
  end

  assign in_beat = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '{default: '0};
      last_q      <= '{default: '0};
      fresh_q     <= 2'b11;
      ax_q        <= 1'b0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
      emag_q      <= '0;
      eneg_q      <= 1'b0;
      dneg_q      <= 1'b0;
      dmag_q      <= '0;
      prod_q      <= '0;
      ip_q        <= '0;
      bound_q     <= '0;
      amag_q      <= '0;
      aneg_q      <= 1'b0;
      nq_q        <= '0;
      pmag_q      <= '0;
      q0_q        <= '0;
      corr_q      <= '{default: '0};
      out_item_q  <= '0;
    end else begin
      // drop the result once taken
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            item_q <= in_item_i;
            corr_q <= '{default: '0};
            ax_q   <= in_item_i.kind || !in_item_i.enabled;
            if (in_item_i.kind) begin
              acc_q   <= '{default: '0};
              last_q  <= '{default: '0};
              fresh_q <= 2'b11;
            end
          end
        end
        ST_PREP: begin
          if (in_dead) begin
            acc_q[ax_q] <= '0;
          end
          if (e_zero) begin
            last_q[ax_q]  <= '0;
            fresh_q[ax_q] <= 1'b1;
          end else if (item_q.time_step != 16'd0) begin
            last_q[ax_q]  <= cur_e;
            fresh_q[ax_q] <= 1'b0;
            emag_q        <= emag;
            eneg_q        <= cur_e[15];
            dneg_q        <= diff[16];
            prod_q        <= mul_p;
          end
        end
        ST_MD1, ST_MD2, ST_MI1: prod_q <= mul_p;
        ST_DIVD: begin
          if (div_rsp.done) begin
            dmag_q      <= dclip;
            acc_q[ax_q] <= acc_sum[ACCUM_WIDTH-1:0];
            prod_q      <= mul_p;
          end
        end
        ST_BND: begin
          if (ki_cur == 16'd0) begin
            bound_q <= prod_q[43:0];
          end
        end
        ST_DIVB: begin
          if (div_rsp.done) begin
            bound_q <= div_rsp.quot[43:0];
          end
        end
        ST_CLMP: begin
          acc_q[ax_q] <= acc_clmp[ACCUM_WIDTH-1:0];
          amag_q      <= amag_full[43:0];
          aneg_q      <= acc_clmp[SW-1];
        end
        ST_MI2: begin
          ip_q   <= prod_q[47:0];
          prod_q <= mul_p;
        end
        // hold the product shifted past the power-of-two part of the scale
        ST_MI3: begin
          nq_q   <= isum[INTEG_SHIFT+28:INTEG_SHIFT];
          prod_q <= mul_p;
        end
        ST_RC1: begin
          pmag_q <= prod_q[31:8];
          prod_q <= mul_p;
        end
        ST_RC2: begin
          q0_q   <= prod_q[RECIP_SHIFT+15:RECIP_SHIFT];
          prod_q <= mul_p;
        end
        ST_SUM: corr_q[ax_q] <= corr_c;
        ST_NEXT: begin
          if (!ax_q) begin
            ax_q <= 1'b1;
          end else begin
            out_valid_q                 <= 1'b1;
            out_item_q.pitch_correction <= corr_q[0];
            out_item_q.roll_correction  <= corr_q[1];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  `DAPB_ASSERT(a_beat_stalls, in_beat |=> in_stall_o, "input not stalled after a beat")
  `DAPB_ASSERT(a_last_loop_emits, (state_q == ST_NEXT && ax_q) |=> out_valid_q, "result lost")
  `DAPB_ASSERT_ALWAYS(a_acc_pitch_sym, acc_q[0] != {1'b1, {(ACCUM_WIDTH-1){1'b0}}}, "pitch acc")
  `DAPB_ASSERT_ALWAYS(a_acc_roll_sym, acc_q[1] != {1'b1, {(ACCUM_WIDTH-1){1'b0}}}, "roll acc")

endmodule

`default_nettype wire

[src/dapb_div.sv]
// ----------------------------------------------------------------------------
// dapb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dapb_div
  import dapb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] dsr_q;

  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   trial_sub;
  logic              ge;
  logic [DIV_DW-1:0] rem_d;

  // Trial subtract of one step
  always_comb begin
    trial     = {rem_q, quo_q[DIV_NW-1]};
    trial_sub = trial - {1'b0, dsr_q};
    ge        = trial >= {1'b0, dsr_q};
    rem_d     = ge ? trial_sub[DIV_DW-1:0] : trial[DIV_DW-1:0];
  end

  // Load on start, then shift one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        quo_q <= {quo_q[DIV_NW-2:0], ge};
        rem_q <= rem_d;
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for the dual-axis balance controller
// Drives update and clear beats under several idling patterns, predicts each
// correction pair with a behavioral copy of both PID loops and compares every
// result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dapb_pkg::*;

  localparam longint ACC_MAX = (64'sd1 <<< 39) - 1;
  localparam longint US_SEC = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  dual_axis_pid_balance dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow registers and loop state
  logic [15:0] gain_q [6];
  logic [14:0] dead_zone_q, limit_q;
  longint accum_q [2];
  int last_err_q [2];
  bit fresh_q [2];

  out_item_t corr_queue[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void clear_loops();
    for (int a = 0; a < 2; a++) begin
      accum_q[a] = 0;
      last_err_q[a] = 0;
      fresh_q[a] = 1;
    end
  endfunction

  // One loop step; ax 0 = pitch, 1 = roll
  function automatic longint loop_step(int ax, int e, longint dt);
    longint gp, gi, gd, lim, bound, x, t, pt, it, dterm, sum;
    int diff;
    gp = gain_q[ax*3];
    gi = gain_q[ax*3+1];
    gd = gain_q[ax*3+2];
    lim = limit_q;
    if ((e < 0 ? -e : e) < dead_zone_q) begin
      accum_q[ax] = 0;
      e = 0;
    end
    if (e == 0) begin
      last_err_q[ax] = 0;
      fresh_q[ax] = 1;
      return 0;
    end
    if (dt == 0) return 0;
    if (fresh_q[ax]) begin
      last_err_q[ax] = e;
      fresh_q[ax] = 0;
    end
    diff = e - last_err_q[ax];
    t = (diff < 0 ? -diff : diff) * gd * US_SEC;
    t = t / (dt << 8);
    if (t > lim) t = lim;
    dterm = diff < 0 ? -t : t;
    x = e * dt;
    if (x > 0 && accum_q[ax] > ACC_MAX - x) accum_q[ax] = ACC_MAX;
    else if (x < 0 && accum_q[ax] < -ACC_MAX - x) accum_q[ax] = -ACC_MAX;
    else accum_q[ax] += x;
    bound = (gi != 0) ? ((lim << 8) * US_SEC) / gi : lim * US_SEC;
    if (bound > ACC_MAX) bound = ACC_MAX;
    if (accum_q[ax] > bound) accum_q[ax] = bound;
    if (accum_q[ax] < -bound) accum_q[ax] = -bound;
    t = (accum_q[ax] < 0 ? -accum_q[ax] : accum_q[ax]);
    // Split the product by the scale so the floor quotient stays exact
    it = (t / 256000000) * gi + ((t % 256000000) * gi) / 256000000;
    if (accum_q[ax] < 0) it = -it;
    pt = ((e < 0 ? -e : e) * gp) >>> 8;
    if (e < 0) pt = -pt;
    sum = pt + it + dterm;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    last_err_q[ax] = e;
    return sum;
  endfunction

  function automatic out_item_t predict_correction(in_item_t b);
    out_item_t r;
    r = '0;
    if (b.kind) clear_loops();
    else if (b.enabled) begin
      r.pitch_correction = 16'(loop_step(0, int'(b.pitch_angle), longint'(b.time_step)));
      r.roll_correction = 16'(loop_step(1, int'(b.roll_angle), longint'(b.time_step)));
    end
    return r;
  endfunction

  // Send one beat, predicting at acceptance
  task automatic send_beat(in_item_t b);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    corr_queue.push_back(predict_correction(b));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < REG_DEAD_ZONE) gain_q[idx] = val;
    else if (idx == REG_DEAD_ZONE) dead_zone_q = val[14:0];
    else limit_q = val[14:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (corr_queue.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_all(logic [15:0] g, logic [15:0] dz, logic [15:0] lim);
    drain();
    for (int k = 0; k < 6; k++) write_reg(cfg_reg_e'(k), g);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_CORR_LIMIT, lim);
  endtask

  function automatic in_item_t make_update(logic en, logic [15:0] p, logic [15:0] r,
                                           logic [15:0] dt);
    in_item_t b;
    b.kind = 1'b0;
    b.enabled = en;
    b.pitch_angle = p;
    b.roll_angle = r;
    b.time_step = dt;
    return b;
  endfunction

  // Randomly stall the result side; check each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (corr_queue.size() == 0) begin
          $display("%0t: unexpected beat actual %h", $time, out_item_o);
          errors++;
        end else begin
          out_item_t want;
          want = corr_queue.pop_front();
          if (want.pitch_correction !== out_item_o.pitch_correction) begin
            $display("%0t: pitch expected %0d actual %0d", $time,
                     want.pitch_correction, out_item_o.pitch_correction);
            errors++;
          end
          if (want.roll_correction !== out_item_o.roll_correction) begin
            $display("%0t: roll expected %0d actual %0d", $time,
                     want.roll_correction, out_item_o.roll_correction);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic test_directed();
    set_all(16'h0100, 16'h0000, 16'h7FFF);
    send_beat(make_update(1, 16'h7FFF, 16'h8000, 16'd1));
    send_beat(make_update(1, 16'h8000, 16'h7FFF, 16'd65535));
    send_beat(make_update(1, 16'h0000, 16'h0000, 16'd100));
    send_beat(make_update(1, 16'h0100, 16'hFF00, 16'd0));
    send_beat(make_update(0, 16'h1234, 16'h4321, 16'd500));
    send_beat(make_update(1, 16'h0200, 16'hFE00, 16'd1000));
    send_beat('{kind: 1'b1, enabled: 1'b0, pitch_angle: 16'h5555, roll_angle: 16'hAAAA,
                time_step: 16'hFFFF});
    send_beat(make_update(1, 16'h0040, 16'h0010, 16'd2000));
    set_all(16'hFFFF, 16'h0080, 16'h0000);
    send_beat(make_update(1, 16'h0050, 16'h0200, 16'd10));
    send_beat(make_update(1, 16'h7FFF, 16'h8001, 16'd65535));
    set_all(16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_beat(make_update(1, 16'h8000, 16'h7FFF, 16'd1));
    send_beat(make_update(1, 16'h0001, 16'h0000, 16'd1));
    // zero integral gain path
    drain();
    write_reg(REG_PITCH_INTEG, 16'h0000);
    write_reg(REG_ROLL_INTEG, 16'h0000);
    write_reg(REG_DEAD_ZONE, 16'hFFFF);
    write_reg(REG_DEAD_ZONE, 16'h0004);
    send_beat(make_update(1, 16'h7000, 16'h9000, 16'd3));
    send_beat(make_update(1, 16'h7000, 16'h9000, 16'd3));
    send_beat('{kind: 1'b1, enabled: 1'b1, pitch_angle: 16'h0, roll_angle: 16'h0,
                time_step: 16'h0});
  endtask

  task automatic test_random(int n);
    in_item_t b;
    for (int k = 0; k < n; k++) begin
      b = make_update(1, 16'($urandom), 16'($urandom), 16'($urandom));
      // favor small time steps and modest angles for deeper integrator use
      if ($urandom_range(3) != 0) b.time_step = 16'($urandom_range(2000));
      if ($urandom_range(2) == 0) b.pitch_angle = 16'($signed($urandom_range(1024)) - 512);
      if ($urandom_range(2) == 0) b.roll_angle = 16'($signed($urandom_range(1024)) - 512);
      if ($urandom_range(19) == 0) b.enabled = 1'b0;
      if ($urandom_range(29) == 0) b.kind = 1'b1;
      send_beat(b);
    end
  endtask

  task automatic random_config();
    drain();
    for (int k = 0; k < 6; k++)
      write_reg(cfg_reg_e'(k), ($urandom_range(1) != 0) ? 16'($urandom)
                                                        : 16'($urandom_range(1024)));
    write_reg(REG_DEAD_ZONE, 16'($urandom_range(64)));
    write_reg(REG_CORR_LIMIT, ($urandom_range(1) != 0) ? 16'($urandom)
                                                       : 16'($urandom_range(8192)));
  endtask

  task automatic test_idling();
    int pat [4][2] = '{'{0, 0}, '{63, 0}, '{0, 63}, '{29, 29}};
    for (int ph = 0; ph < 4; ph++) begin
      random_config();
      send_idle_pct = pat[ph][0];
      recv_stall_pct = pat[ph][1];
      test_random(250);
      // hold off until the block has delivered everything
      drain();
      test_random(250);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    for (int k = 0; k < 6; k++) gain_q[k] = '0;
    dead_zone_q = '0;
    limit_q = '0;
    clear_loops();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idling();
    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && corr_queue.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule

[dual_axis_pid_balance.f]
+incdir+src
src/dapb_pkg.sv
src/dapb_div.sv
src/dual_axis_pid_balance.sv
tb/testbench.sv
